// ----- sv/dcdc_pkg.sv -----
// Shared types, constants and calendar tables for the day-count / date converter.
`default_nettype none

package dcdc_pkg;

  // Calendar constants
  localparam int unsigned BASE_YEAR  = 1800;
  localparam int unsigned YEAR_DAYS  = 365;
  localparam int unsigned CYCLE_DAYS = (365 * 4) + 1;
  localparam int unsigned FEB29_SLOT = 31 + 28;

  // Reciprocal of CYCLE_DAYS: floor(2^42 / 1461); the quotient it gives is low by at most one
  localparam int unsigned RECIP_M     = 32'd3010298775;
  localparam int          RECIP_SHIFT = 42;
  localparam int          QUOT_W      = 64 - RECIP_SHIFT;

  // Pipeline depths: divider stages, calendar stages, then the output register
  localparam int DIV_LAT  = 4;
  localparam int DATE_LAT = DIV_LAT + 2;
  localparam int OUT_LAT  = DATE_LAT + 1;

  // Command codes
  localparam logic CMD_TO_DATE = 1'b0;
  localparam logic CMD_TO_DAYS = 1'b1;

  typedef struct packed {
    logic        command;
    logic [31:0] total_days;
    logic [15:0] in_year;
    logic [3:0]  in_month;
    logic [4:0]  in_day;
  } in_t;

  typedef struct packed {
    logic [15:0] out_year;
    logic [3:0]  out_month;
    logic [4:0]  out_day;
    logic [8:0]  cycle_day_index;
    logic [31:0] day_total;
  } out_t;

  // Control that travels alongside each item
  typedef struct packed {
    logic vld;
    logic cmd;
  } ctl_t;

  // First day index of each month in a 366-day year
  function automatic logic [8:0] leap_month_start(input logic [3:0] m);
    unique case (m)
      4'd0:    return 9'd0;
      4'd1:    return 9'd31;
      4'd2:    return 9'd60;
      4'd3:    return 9'd91;
      4'd4:    return 9'd121;
      4'd5:    return 9'd152;
      4'd6:    return 9'd182;
      4'd7:    return 9'd213;
      4'd8:    return 9'd244;
      4'd9:    return 9'd274;
      4'd10:   return 9'd305;
      4'd11:   return 9'd335;
      default: return 9'd0;
    endcase
  endfunction

  // Days in the first n months of a common year; beyond twelve it stays at a full year
  function automatic logic [8:0] month_days_before(input logic [3:0] n);
    unique case (n)
      4'd0:    return 9'd0;
      4'd1:    return 9'd31;
      4'd2:    return 9'd59;
      4'd3:    return 9'd90;
      4'd4:    return 9'd120;
      4'd5:    return 9'd151;
      4'd6:    return 9'd181;
      4'd7:    return 9'd212;
      4'd8:    return 9'd243;
      4'd9:    return 9'd273;
      4'd10:   return 9'd304;
      4'd11:   return 9'd334;
      default: return 9'd365;
    endcase
  endfunction

endpackage

`default_nettype wire

// ----- sv/dcdc_divmod.sv -----
// Four-stage divide of the day count by the four-year cycle length, by reciprocal multiply.
`default_nettype none

module dcdc_divmod (
  input  logic            clk,
  input  logic            rst_n,
  input  dcdc_pkg::ctl_t  ctl_i,
  input  logic [31:0]     total_i,
  output dcdc_pkg::ctl_t  ctl_o,
  output logic [15:0]     cyc_o,
  output logic [10:0]     idx_o
);
  import dcdc_pkg::*;

  ctl_t               ctl1_r, ctl2_r, ctl3_r, ctl4_r;
  logic [63:0]        prod;
  logic [31:0]        tot1_r, tot2_r;
  logic [QUOT_W-1:0]  q1_r, q2_r, q3_r;
  logic [31:0]        mul2_r;
  logic [31:0]        diff;
  logic [11:0]        rem3_r;
  logic               wrap;
  logic [QUOT_W-1:0]  q_nxt;
  logic [11:0]        rem_nxt;
  logic [15:0]        cyc4_r;
  logic [10:0]        idx4_r;

  // control pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
      ctl2_r <= '0;
      ctl3_r <= '0;
      ctl4_r <= '0;
    end else begin
      ctl1_r <= ctl_i;
      ctl2_r <= ctl1_r;
      ctl3_r <= ctl2_r;
      ctl4_r <= ctl3_r;
    end
  end

  // stage 1: estimate quotient
  assign prod = 64'(total_i) * 64'(RECIP_M);

  // stage 3: remainder from the estimate, below twice the cycle length
  assign diff = tot2_r - mul2_r;

  // stage 4: one-step correction
  always_comb begin
    wrap    = rem3_r >= 12'(CYCLE_DAYS);
    q_nxt   = wrap ? q3_r + QUOT_W'(1) : q3_r;
    rem_nxt = wrap ? rem3_r - 12'(CYCLE_DAYS) : rem3_r;
  end

  always_ff @(posedge clk) begin
    tot1_r <= total_i;
    q1_r   <= prod[63:RECIP_SHIFT];
    tot2_r <= tot1_r;
    q2_r   <= q1_r;
    mul2_r <= 32'(q1_r) * 32'(CYCLE_DAYS);
    q3_r   <= q2_r;
    rem3_r <= diff[11:0];
    cyc4_r <= q_nxt[15:0];
    idx4_r <= rem_nxt[10:0];
  end

  assign ctl_o = ctl4_r;
  assign cyc_o = cyc4_r;
  assign idx_o = idx4_r;

  a_est_close: assert property (@(posedge clk) disable iff (!rst_n)
    ctl3_r.vld |-> rem3_r < 12'(2 * CYCLE_DAYS))
    else $error("quotient estimate off by more than one");

  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    ctl4_r.vld |-> idx4_r < 11'(CYCLE_DAYS))
    else $error("cycle day index out of range");

endmodule

`default_nettype wire

// ----- sv/dcdc_cal.sv -----
// Two calendar stages: year within the cycle, then month and day from the leap-year table.
`default_nettype none

module dcdc_cal (
  input  logic            clk,
  input  logic            rst_n,
  input  dcdc_pkg::ctl_t  ctl_i,
  input  logic [15:0]     cyc_i,
  input  logic [10:0]     idx_i,
  output dcdc_pkg::ctl_t  ctl_o,
  output logic [15:0]     year_o,
  output logic [3:0]      month_o,
  output logic [4:0]      day_o,
  output logic [8:0]      didx_o
);
  import dcdc_pkg::*;

  ctl_t        ctl5_r, ctl6_r;
  logic        later;
  logic [10:0] rest;
  logic [10:0] r;
  logic [1:0]  yoff;
  logic [1:0]  yadd_nxt;
  logic [8:0]  didx_nxt;
  logic [15:0] cyc5_r;
  logic [1:0]  yadd5_r;
  logic [8:0]  didx5_r;
  logic [3:0]  month_nxt;
  logic [8:0]  mday;
  logic [4:0]  day_nxt;
  logic [15:0] year_nxt;
  logic [15:0] year6_r;
  logic [3:0]  month6_r;
  logic [4:0]  day6_r;
  logic [8:0]  didx6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl5_r <= '0;
      ctl6_r <= '0;
    end else begin
      ctl5_r <= ctl_i;
      ctl6_r <= ctl5_r;
    end
  end

  // stage 5: years after the leap year are 365 days, their index skips Feb 29
  always_comb begin
    later = idx_i > 11'(YEAR_DAYS);
    rest  = idx_i - 11'(YEAR_DAYS + 1);
    if (rest >= 11'(2 * YEAR_DAYS)) begin
      yoff = 2'd2;
      r    = rest - 11'(2 * YEAR_DAYS);
    end else if (rest >= 11'(YEAR_DAYS)) begin
      yoff = 2'd1;
      r    = rest - 11'(YEAR_DAYS);
    end else begin
      yoff = 2'd0;
      r    = rest;
    end
    if (later) begin
      yadd_nxt = yoff + 2'd1;
      didx_nxt = (r[8:0] >= 9'(FEB29_SLOT)) ? r[8:0] + 9'd1 : r[8:0];
    end else begin
      yadd_nxt = 2'd0;
      didx_nxt = idx_i[8:0];
    end
  end

  // stage 6: month lookup, day of month, year
  always_comb begin
    month_nxt = 4'd0;
    for (int k = 1; k < 12; k++) begin
      if (didx5_r >= leap_month_start(4'(k))) month_nxt = 4'(k);
    end
    mday     = didx5_r - leap_month_start(month_nxt) + 9'd1;
    day_nxt  = mday[4:0];
    year_nxt = 16'(BASE_YEAR) + {cyc5_r[13:0], yadd5_r};
  end

  always_ff @(posedge clk) begin
    cyc5_r   <= cyc_i;
    yadd5_r  <= yadd_nxt;
    didx5_r  <= didx_nxt;
    year6_r  <= year_nxt;
    month6_r <= month_nxt;
    day6_r   <= day_nxt;
    didx6_r  <= didx5_r;
  end

  assign ctl_o   = ctl6_r;
  assign year_o  = year6_r;
  assign month_o = month6_r;
  assign day_o   = day6_r;
  assign didx_o  = didx6_r;

  a_no_feb29: assert property (@(posedge clk) disable iff (!rst_n)
    ctl5_r.vld && yadd5_r != 2'd0 |-> didx5_r != 9'(FEB29_SLOT))
    else $error("common year landed on the Feb 29 slot");

  a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
    ctl6_r.vld |-> month6_r <= 4'd11 && day6_r != 5'd0 && didx6_r <= 9'(YEAR_DAYS))
    else $error("date fields out of range");

endmodule

`default_nettype wire

// ----- sv/dcdc_d2d.sv -----
// Date-to-day-count pipeline, three working stages and a delay line to match the date path.
`default_nettype none

module dcdc_d2d (
  input  logic        clk,
  input  logic [15:0] year_i,
  input  logic [3:0]  month_i,
  input  logic [4:0]  day_i,
  output logic [31:0] total_o
);
  import dcdc_pkg::*;

  localparam int DLY = DATE_LAT - 3;

  logic        neg;
  logic [15:0] n;
  logic        leap;
  logic        neg1_r, neg2_r;
  logic [24:0] prod1_r;
  logic [13:0] n4_1_r;
  logic [8:0]  moff1_r;
  logic [4:0]  day1_r;
  logic [24:0] mag2_r;
  logic [9:0]  add2_r;
  logic [31:0] tot3_r;
  logic [31:0] dly_r [DLY];

  // stage 1: distance from the base year and month offset
  always_comb begin
    neg  = year_i < 16'(BASE_YEAR);
    n    = neg ? 16'(BASE_YEAR) - year_i : year_i - 16'(BASE_YEAR);
    leap = (year_i[1:0] == 2'b00) && (month_i >= 4'd2);
  end

  always_ff @(posedge clk) begin
    neg1_r  <= neg;
    prod1_r <= 25'(n) * 25'(YEAR_DAYS);
    n4_1_r  <= n[15:2];
    moff1_r <= month_days_before(month_i) + 9'(leap);
    day1_r  <= day_i;
    // stage 2: magnitude of the year term
    neg2_r  <= neg1_r;
    mag2_r  <= prod1_r + 25'(n4_1_r);
    add2_r  <= 10'(moff1_r) + 10'(day1_r);
    // stage 3: signed year term plus month and day, modulo 2^32
    tot3_r  <= neg2_r ? 32'(add2_r) - 32'(mag2_r) : 32'(mag2_r) + 32'(add2_r);
    dly_r[0] <= tot3_r;
    for (int k = 1; k < DLY; k++) dly_r[k] <= dly_r[k-1];
  end

  assign total_o = dly_r[DLY-1];

endmodule

`default_nettype wire

// ----- sv/day_count_date_converter_core.sv -----
// Top level of the day-count / calendar-date converter.
//
//   channel  ports                  handshake
//   input    start, busy, in_item   taken when start is high and busy is low
//   result   out_valid, out_item    one-cycle strobe, no hold-off
//
// One item is taken every clock cycle; busy stays low.
// Each result is registered through four divider stages
// (32x32 reciprocal multiply, back-multiply, remainder, correction), two
// calendar stages and the output register; day totals come from the matched dcdc_d2d path.
// Reset (rst_n, synchronous) clears the valid bits; items in flight are dropped.
// Nothing stalls: results leave in order, one per item.
`default_nettype none

module day_count_date_converter_core (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  dcdc_pkg::in_t  in_item,
  output logic           busy,
  output logic           out_valid,
  output dcdc_pkg::out_t out_item
);
  import dcdc_pkg::*;

  ctl_t        ctl_in;
  ctl_t        div_ctl;
  logic [15:0] div_cyc;
  logic [10:0] div_idx;
  ctl_t        cal_ctl;
  logic [15:0] cal_year;
  logic [3:0]  cal_month;
  logic [4:0]  cal_day;
  logic [8:0]  cal_didx;
  logic [31:0] d2d_total;
  out_t        out_nxt;
  out_t        out_r;
  logic        out_valid_r;

  assign busy       = 1'b0;
  assign ctl_in.vld = start && !busy;
  assign ctl_in.cmd = in_item.command;

  dcdc_divmod u_divmod (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl_i   (ctl_in),
    .total_i (in_item.total_days),
    .ctl_o   (div_ctl),
    .cyc_o   (div_cyc),
    .idx_o   (div_idx)
  );

  dcdc_cal u_cal (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl_i   (div_ctl),
    .cyc_i   (div_cyc),
    .idx_i   (div_idx),
    .ctl_o   (cal_ctl),
    .year_o  (cal_year),
    .month_o (cal_month),
    .day_o   (cal_day),
    .didx_o  (cal_didx)
  );

  dcdc_d2d u_d2d (
    .clk     (clk),
    .year_i  (in_item.in_year),
    .month_i (in_item.in_month),
    .day_i   (in_item.in_day),
    .total_o (d2d_total)
  );

  // pick the result for the item's command
  always_comb begin
    out_nxt = '0;
    if (cal_ctl.cmd == CMD_TO_DAYS) begin
      out_nxt.day_total = d2d_total;
    end else begin
      out_nxt.out_year        = cal_year;
      out_nxt.out_month       = cal_month;
      out_nxt.out_day         = cal_day;
      out_nxt.cycle_day_index = cal_didx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cal_ctl.vld;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##OUT_LAT out_valid_r)
    else $error("item taken without a result at the expected cycle");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(start, OUT_LAT))
    else $error("result without a matching item");

  a_day_total_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.day_total != 32'd0 |->
      out_r.out_year == 16'd0 && out_r.out_month == 4'd0 &&
      out_r.out_day == 5'd0 && out_r.cycle_day_index == 9'd0)
    else $error("date fields set on a day-count result");

endmodule

`default_nettype wire
